>>> src/rabt_pkg.sv
// Package for the radial alpha brush texel pipeline.
// Types, widths, register indexes and byte-lane helpers; no dependencies.
package rabt_pkg;

   localparam int unsigned NumStages  = 34;
   localparam int unsigned SqrtFirst  = 4;
   localparam int unsigned SqrtSteps  = 19;
   localparam int unsigned NumStage   = SqrtFirst + SqrtSteps;
   localparam int unsigned DvdStage   = NumStage + 1;
   localparam int unsigned DivFirst   = DvdStage + 1;
   localparam int unsigned DivSteps   = 8;
   localparam int unsigned OutStage   = DivFirst + DivSteps;

   typedef enum logic [2:0] {
      CSR_CENTER_X     = 3'd0,
      CSR_CENTER_Y     = 3'd1,
      CSR_INNER_RADIUS = 3'd2,
      CSR_OUTER_RADIUS = 3'd3,
      CSR_INNER_ALPHA  = 3'd4,
      CSR_OUTER_ALPHA  = 3'd5,
      CSR_LAYER_SELECT = 3'd6,
      CSR_ERASE_MODE   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        pix;
      logic [1:0]         lane;
      logic               act;
      logic               disc;
      logic               ring;
      logic signed [18:0] dx;
      logic signed [18:0] dy;
      logic [36:0]        sqx;
      logic [36:0]        sqy;
      logic [37:0]        rad;
      logic [20:0]        rem;
      logic [18:0]        root;
      logic signed [29:0] num;
      logic [27:0]        dvd;
      logic [7:0]         quo;
   } stage_type;

   function automatic logic [7:0] lane_byte(input logic [31:0] pix, input logic [1:0] lane);
      logic [7:0] b;
      unique case (lane)
         2'd0: b = pix[31:24];
         2'd1: b = pix[23:16];
         2'd2: b = pix[15:8];
         default: b = pix[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [31:0] lane_put(input logic [31:0] pix, input logic [1:0] lane,
                                            input logic [7:0] b);
      logic [31:0] r;
      r = pix;
      unique case (lane)
         2'd0: r[31:24] = b;
         2'd1: r[23:16] = b;
         2'd2: r[15:8]  = b;
         default: r[7:0] = b;
      endcase
      return r;
   endfunction

endpackage

>>> src/radial_alpha_brush_texel.sv
// Top level of the radial alpha brush texel pipeline.
// Uses rabt_pkg for stage payload, register indexes and byte-lane helpers.
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+---------------------
//  req     | texel_x, texel_y, pixel_in          | req_valid / req_stall
//  rsp     | pixel_out                           | rsp_valid / rsp_stall
//  csr     | csr_index, csr_data                 | csr_valid / csr_ready
//
// One beat per cycle enters while req_stall is low; the pipe's depth comes mostly from
// the 19 one-bit square root steps and the 8 one-bit divide steps.
// Reset clears the stage valid bits and loads register defaults.
// A held result on rsp freezes the whole pipe; req_stall follows it.
module radial_alpha_brush_texel (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_texel_x,
   input  logic [7:0]  req_texel_y,
   input  logic [31:0] req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);

   logic signed [17:0] center_x_ff, center_y_ff;
   logic [19:0]        inner_radius_ff, outer_radius_ff;
   logic [7:0]         inner_alpha_ff, outer_alpha_ff;
   logic [2:0]         layer_select_ff;
   logic               erase_mode_ff;
   logic [39:0]        ri2_ff, ro2_ff;

   logic                 adv;
   logic [rabt_pkg::NumStages-1:0] valid_ff;
   rabt_pkg::stage_type  st_ff [rabt_pkg::NumStages];
   rabt_pkg::stage_type  st_in [rabt_pkg::NumStages];

   logic [19:0] den;
   assign den = outer_radius_ff - inner_radius_ff;

   assign csr_ready     = 1'b1;
   assign adv           = !(valid_ff[rabt_pkg::NumStages-1] && rsp_stall);
   assign req_stall     = !adv;
   assign rsp_valid     = valid_ff[rabt_pkg::NumStages-1];
   assign rsp_pixel_out = st_ff[rabt_pkg::NumStages-1].pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         inner_radius_ff <= '0;
         outer_radius_ff <= '0;
         inner_alpha_ff  <= 8'hff;
         outer_alpha_ff  <= '0;
         layer_select_ff <= 3'd1;
         erase_mode_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (rabt_pkg::csr_index_type'(csr_index))
            rabt_pkg::CSR_CENTER_X:     center_x_ff     <= csr_data[17:0];
            rabt_pkg::CSR_CENTER_Y:     center_y_ff     <= csr_data[17:0];
            rabt_pkg::CSR_INNER_RADIUS: inner_radius_ff <= csr_data;
            rabt_pkg::CSR_OUTER_RADIUS: outer_radius_ff <= csr_data;
            rabt_pkg::CSR_INNER_ALPHA:  inner_alpha_ff  <= csr_data[7:0];
            rabt_pkg::CSR_OUTER_ALPHA:  outer_alpha_ff  <= csr_data[7:0];
            rabt_pkg::CSR_LAYER_SELECT: layer_select_ff <= csr_data[2:0];
            rabt_pkg::CSR_ERASE_MODE:   erase_mode_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ri2_ff <= inner_radius_ff * inner_radius_ff;
      ro2_ff <= outer_radius_ff * outer_radius_ff;
   end

   // texel position to 1/256 units, offset from centre
   always_comb begin
      st_in[0]      = '0;
      st_in[0].pix  = req_pixel_in;
      st_in[0].act  = (layer_select_ff >= 3'd1) && (layer_select_ff <= 3'd4);
      st_in[0].lane = 2'(layer_select_ff - 3'd1);
      st_in[0].dx   = {3'b000, req_texel_x, 8'h00} - {center_x_ff[17], center_x_ff};
      st_in[0].dy   = {3'b000, req_texel_y, 8'h00} - {center_y_ff[17], center_y_ff};
   end

   always_comb begin
      logic signed [37:0] px, py;
      px       = st_ff[0].dx * st_ff[0].dx;
      py       = st_ff[0].dy * st_ff[0].dy;
      st_in[1]     = st_ff[0];
      st_in[1].sqx = px[36:0];
      st_in[1].sqy = py[36:0];
   end

   always_comb begin
      st_in[2]     = st_ff[1];
      st_in[2].rad = {1'b0, st_ff[1].sqx} + {1'b0, st_ff[1].sqy};
   end

   always_comb begin
      st_in[3]      = st_ff[2];
      st_in[3].disc = {2'b00, st_ff[2].rad} <= ri2_ff;
      st_in[3].ring = {2'b00, st_ff[2].rad} <= ro2_ff;
      st_in[3].rem  = '0;
      st_in[3].root = '0;
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < rabt_pkg::SqrtSteps; k++) begin : g_sqrt
      always_comb begin
         logic [22:0] rt;
         logic [22:0] tr;
         rt = {st_ff[rabt_pkg::SqrtFirst+k-1].rem, st_ff[rabt_pkg::SqrtFirst+k-1].rad[37:36]};
         tr = {2'b00, st_ff[rabt_pkg::SqrtFirst+k-1].root, 2'b01};
         st_in[rabt_pkg::SqrtFirst+k]     = st_ff[rabt_pkg::SqrtFirst+k-1];
         st_in[rabt_pkg::SqrtFirst+k].rad = {st_ff[rabt_pkg::SqrtFirst+k-1].rad[35:0], 2'b00};
         if (rt >= tr) begin
            st_in[rabt_pkg::SqrtFirst+k].rem  = 21'(rt - tr);
            st_in[rabt_pkg::SqrtFirst+k].root =
               {st_ff[rabt_pkg::SqrtFirst+k-1].root[17:0], 1'b1};
         end else begin
            st_in[rabt_pkg::SqrtFirst+k].rem  = rt[20:0];
            st_in[rabt_pkg::SqrtFirst+k].root =
               {st_ff[rabt_pkg::SqrtFirst+k-1].root[17:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic signed [8:0]  da;
      logic signed [20:0] dl;
      da = $signed({1'b0, inner_alpha_ff}) - $signed({1'b0, outer_alpha_ff});
      dl = $signed({1'b0, outer_radius_ff}) -
           $signed({2'b00, st_ff[rabt_pkg::NumStage-1].root});
      st_in[rabt_pkg::NumStage]     = st_ff[rabt_pkg::NumStage-1];
      st_in[rabt_pkg::NumStage].num = da * dl;
   end

   // clamp negative numerators to 0; erase mode divides 255*D minus that value
   always_comb begin
      logic [27:0] np;
      logic [27:0] full;
      np   = st_ff[rabt_pkg::NumStage].num[29] ? 28'd0 : st_ff[rabt_pkg::NumStage].num[27:0];
      full = {den, 8'h00} - {8'h00, den};
      st_in[rabt_pkg::DvdStage]     = st_ff[rabt_pkg::NumStage];
      st_in[rabt_pkg::DvdStage].dvd = erase_mode_ff ? full - np : np;
      st_in[rabt_pkg::DvdStage].quo = '0;
   end

   for (genvar j = 0; j < rabt_pkg::DivSteps; j++) begin : g_div
      always_comb begin
         logic [27:0] ds;
         ds = 28'({8'h00, den} << (rabt_pkg::DivSteps - 1 - j));
         st_in[rabt_pkg::DivFirst+j] = st_ff[rabt_pkg::DivFirst+j-1];
         if (st_ff[rabt_pkg::DivFirst+j-1].dvd >= ds) begin
            st_in[rabt_pkg::DivFirst+j].dvd = st_ff[rabt_pkg::DivFirst+j-1].dvd - ds;
            st_in[rabt_pkg::DivFirst+j].quo[rabt_pkg::DivSteps-1-j] = 1'b1;
         end
      end
   end

   always_comb begin
      rabt_pkg::stage_type s;
      logic [7:0] a;
      logic [7:0] q;
      logic [7:0] na;
      s  = st_ff[rabt_pkg::OutStage-1];
      a  = rabt_pkg::lane_byte(s.pix, s.lane);
      q  = s.quo;
      if (s.disc) begin
         na = erase_mode_ff ? 8'h00 : inner_alpha_ff;
      end else if (erase_mode_ff) begin
         na = (q < a) ? q : a;
      end else begin
         na = (q > a) ? q : a;
      end
      st_in[rabt_pkg::OutStage] = s;
      if (s.act && (s.disc || s.ring)) begin
         st_in[rabt_pkg::OutStage].pix = rabt_pkg::lane_put(s.pix, s.lane, na);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[rabt_pkg::NumStages-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < rabt_pkg::NumStages; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

endmodule

>>> src/rabt_checker.sv
// Port-level checker for radial_alpha_brush_texel, bound to the top level.
// Depends on nothing but the top level's ports.
module rabt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pixel_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out))
      else $error("rsp beat changed while stalled");

   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a held rsp beat");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat after reset");

endmodule

bind radial_alpha_brush_texel rabt_checker u_rabt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out)
);

>>> bench/radial_alpha_brush_texel_tb.sv
// Self-checking bench for radial_alpha_brush_texel: directed and random texels
// under several brush settings, results checked in order against a predictor.
// Depends on rabt_pkg and the radial_alpha_brush_texel RTL.
module radial_alpha_brush_texel_tb;
   timeunit 1ns;
   timeprecision 1ps;

   class brush_scoreboard;
      logic signed [17:0] cx, cy;
      logic [19:0] ri, ro;
      logic [7:0] ia, oa;
      logic [2:0] layer;
      logic erase;
      logic [31:0] pending[$];
      int errors;
      int checked;

      function void restore();
         cx = 0; cy = 0; ri = 0; ro = 0; ia = 8'd255; oa = 0; layer = 3'd1; erase = 0;
      endfunction

      function void set_reg(rabt_pkg::csr_index_type idx, logic [19:0] v);
         case (idx)
            rabt_pkg::CSR_CENTER_X:     cx = v[17:0];
            rabt_pkg::CSR_CENTER_Y:     cy = v[17:0];
            rabt_pkg::CSR_INNER_RADIUS: ri = v;
            rabt_pkg::CSR_OUTER_RADIUS: ro = v;
            rabt_pkg::CSR_INNER_ALPHA:  ia = v[7:0];
            rabt_pkg::CSR_OUTER_ALPHA:  oa = v[7:0];
            rabt_pkg::CSR_LAYER_SELECT: layer = v[2:0];
            default:                    erase = v[0];
         endcase
      endfunction

      function longint isqrt(longint v);
         longint r, b;
         r = 0;
         b = 64'sd1 << 62;
         while (b > v) b = b >>> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >>> 1) + b;
            end else begin
               r = r >>> 1;
            end
            b = b >>> 2;
         end
         return r;
      endfunction

      function logic [31:0] brush(logic [7:0] tx, logic [7:0] ty, logic [31:0] pix);
         int sh;
         longint dx, dy, d2, a, len, den, num, t;
         case (layer)
            3'd1: sh = 24;
            3'd2: sh = 16;
            3'd3: sh = 8;
            3'd4: sh = 0;
            default: return pix;
         endcase
         dx = longint'(tx) * 256 - longint'(cx);
         dy = longint'(ty) * 256 - longint'(cy);
         d2 = dx * dx + dy * dy;
         a = (pix >> sh) & 32'hff;
         if (d2 <= longint'(ri) * longint'(ri)) begin
            a = erase ? 0 : longint'(ia);
         end else if (d2 <= longint'(ro) * longint'(ro)) begin
            len = isqrt(d2);
            den = longint'(ro) - longint'(ri);
            num = (longint'(ia) - longint'(oa)) * (longint'(ro) - len);
            if (den <= 0) return pix;
            if (erase) begin
               t = 255 * den - num;
               if (t < 0) t = 0;
               if (t < a * den) a = t / den;
            end else if (num > a * den) begin
               a = num / den;
            end
         end else begin
            return pix;
         end
         if (a < 0) a = 0;
         if (a > 255) a = 255;
         pix[sh +: 8] = a[7:0];
         return pix;
      endfunction

      function void note_texel(logic [7:0] tx, logic [7:0] ty, logic [31:0] pix);
         pending.push_back(brush(tx, ty, pix));
      endfunction

      function void check_pixel(logic [31:0] got);
         logic [31:0] want;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat: pixel_out %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("pixel_out mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0, csr_valid = 0, csr_ready;
   logic [7:0] req_texel_x = 0, req_texel_y = 0;
   logic [31:0] req_pixel_in = 0, rsp_pixel_out;
   logic [2:0] csr_index = 0;
   logic [19:0] csr_data = 0;

   radial_alpha_brush_texel dut (.*);

   brush_scoreboard sb = new();
   int send_idle = 0, recv_idle = 0;
   bit hold_rsp = 0;
   int quiet = 0;
   int sent = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_texel(req_texel_x, req_texel_y, req_pixel_in);
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel(rsp_pixel_out);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("radial_alpha_brush_texel_tb NOT OK");
         $finish;
      end
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle);
   end

   task automatic write_reg(rabt_pkg::csr_index_type idx, logic [19:0] v);
      csr_valid <= 1; csr_index <= idx; csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_texel(logic [7:0] tx, logic [7:0] ty, logic [31:0] pix);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_texel_x <= tx; req_texel_y <= ty; req_pixel_in <= pix;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic idle_req();
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic random_brush(bit extreme);
      logic [19:0] a, b;
      a = 20'($urandom_range(40000));
      b = 20'(a + $urandom_range(40000));
      if (extreme) begin
         a = $urandom_range(1) ? 20'hfffff : 20'h00000;
         b = $urandom_range(1) ? 20'hfffff : 20'h00000;
      end else if ($urandom_range(7) == 0) begin
         b = 20'(a - $urandom_range(100));
      end
      write_reg(rabt_pkg::CSR_CENTER_X, extreme ? ($urandom_range(1) ? 20'h1ffff : 20'h20000)
                                                : 20'($urandom()));
      write_reg(rabt_pkg::CSR_CENTER_Y, extreme ? ($urandom_range(1) ? 20'h1ffff : 20'h20000)
                                                : 20'($urandom()));
      write_reg(rabt_pkg::CSR_INNER_RADIUS, a);
      write_reg(rabt_pkg::CSR_OUTER_RADIUS, b);
      write_reg(rabt_pkg::CSR_INNER_ALPHA, 20'($urandom_range(255)));
      write_reg(rabt_pkg::CSR_OUTER_ALPHA, 20'($urandom_range(255)));
      write_reg(rabt_pkg::CSR_LAYER_SELECT,
                20'($urandom_range(9) < 8 ? $urandom_range(1, 4) : $urandom_range(7)));
      write_reg(rabt_pkg::CSR_ERASE_MODE, 20'($urandom_range(1)));
   endtask

   initial begin
      int k, phase;
      sb.restore();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: defaults, then a centred brush across the ring with each layer
      send_texel(8'd0, 8'd0, 32'h0000_0000);
      send_texel(8'd255, 8'd255, 32'hffff_ffff);
      drain();
      write_reg(rabt_pkg::CSR_CENTER_X, 20'h08000);
      write_reg(rabt_pkg::CSR_CENTER_Y, 20'h08000);
      write_reg(rabt_pkg::CSR_INNER_RADIUS, 20'd2000);
      write_reg(rabt_pkg::CSR_OUTER_RADIUS, 20'd9000);
      write_reg(rabt_pkg::CSR_INNER_ALPHA, 20'd200);
      write_reg(rabt_pkg::CSR_OUTER_ALPHA, 20'd20);
      for (k = 0; k < 8; k++) begin
         drain();
         write_reg(rabt_pkg::CSR_LAYER_SELECT, 20'(k));
         write_reg(rabt_pkg::CSR_ERASE_MODE, {19'd0, k[0]});
         send_texel(8'd128, 8'd128, 32'h5a5a_5a5a);
         send_texel(8'd150, 8'd140, 32'h0000_0000);
         send_texel(8'(120 + k), 8'd160, 32'hffff_ffff);
      end
      drain();
      write_reg(rabt_pkg::CSR_OUTER_ALPHA, 20'd250);
      send_texel(8'd150, 8'd130, 32'h8080_8080);
      drain();
      write_reg(rabt_pkg::CSR_OUTER_RADIUS, 20'd1000);
      send_texel(8'd200, 8'd200, 32'h1234_5678);
      send_texel(8'd128, 8'd128, 32'h1234_5678);
      for (phase = 0; phase < 3; phase++) begin
         send_idle = phase == 0 ? 15 : phase == 1 ? 68 : 0;
         recv_idle = phase == 0 ? 68 : phase == 1 ? 15 : 0;
         for (k = 0; k < 520; k++) begin
            if (k % 65 == 0) begin
               idle_req();
               drain();
               random_brush(k % 260 == 0);
               if ($urandom_range(1)) begin
                  write_reg(rabt_pkg::CSR_CENTER_X, 20'($urandom_range(255) * 256));
                  write_reg(rabt_pkg::CSR_CENTER_Y, 20'($urandom_range(255) * 256));
               end
            end
            if (k == 300) begin
               hold_rsp = 1;
               fork begin repeat (120) @(posedge clock); hold_rsp = 0; end join_none
            end
            send_texel(8'($urandom_range(255)), 8'($urandom_range(255)), $urandom());
         end
      end
      idle_req();
      drain();
      $display("covered %0d texels over layers 0..7, paint and erase, disc/ring/outside",
               sent);
      if (sb.errors == 0)
         $display("radial_alpha_brush_texel_tb OK");
      else
         $display("radial_alpha_brush_texel_tb NOT OK");
      $finish;
   end
endmodule
